[rtl/core/swhr_pkg.sv]
`timescale 1ns / 1ps

package swhr_pkg;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_DRIVE   = 2'd1,
    PH_RELEASE = 2'd2,
    PH_LISTEN  = 2'd3
  } phase_t;

  // configuration register indexes
  localparam logic [7:0] REG_START_LOW_TICKS = 8'd0;
  localparam logic [7:0] REG_RELEASE_TICKS   = 8'd1;
  localparam logic [7:0] REG_ONE_THRESHOLD   = 8'd2;
  localparam logic [7:0] REG_RUN_TIMEOUT     = 8'd3;

  localparam logic [14:0] START_LOW_RESET = 15'd18000;
  localparam logic [7:0]  RELEASE_RESET   = 8'd40;
  localparam logic [7:0]  THRESHOLD_RESET = 8'd16;
  localparam logic [7:0]  TIMEOUT_RESET   = 8'd255;

  localparam logic [5:0] DATA_BITS     = 6'd40;
  localparam logic [6:0] FIRST_BIT_TRN = 7'd4;

  typedef struct packed {
    logic [14:0] start_low_ticks;
    logic [7:0]  release_ticks;
    logic [7:0]  one_threshold;
    logic [7:0]  run_timeout;
  } cfg_t;

  typedef struct packed {
    phase_t          phase;
    logic [14:0]     phase_ticks;
    logic [7:0]      run_length;
    logic            previous_level;
    logic [6:0]      transition_index;
    logic [5:0]      bit_count;
    logic [4:0][7:0] rx_bytes;   // index 0 is the first byte received
  } state_t;

  typedef struct packed {
    logic            drive_low;
    logic            busy_res;
    logic            done_res;
    logic            reading_ok;
    logic [3:0][7:0] data_bytes;
  } result_t;

endpackage

[rtl/core/single_wire_humidity_sensor_reader.sv]
`timescale 1ns / 1ps

// Single-wire humidity/temperature sensor reader. Feed one item per microsecond
// tick with the sampled wire level and a start request; every item returns one
// result with the wire drive, busy and, on the tick the reading ends, done, ok
// and the four data bytes. The protocol state and one result register sit
// either side of a single pass of step logic, so a new item is taken every
// cycle unless the result register is full and not being taken.
// Configuration writes are taken at once and must arrive while the block is idle.
module single_wire_humidity_sensor_reader #(
  parameter int MAX_TRANSITIONS = 85
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] start_request, [1] wire_level, [7:2] zero
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [0] drive_low, [1] busy_res, [2] done_res,
                                 // [3] reading_ok, [11:4] humidity_whole,
                                 // [19:12] humidity_fraction,
                                 // [27:20] temperature_whole,
                                 // [35:28] temperature_fraction, [39:36] zero
);

  swhr_pkg::cfg_t    cfg;
  swhr_pkg::state_t  state;
  swhr_pkg::state_t  state_next;
  swhr_pkg::result_t result;
  logic              in_accept;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign in_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_low_ticks <= swhr_pkg::START_LOW_RESET;
      cfg.release_ticks   <= swhr_pkg::RELEASE_RESET;
      cfg.one_threshold   <= swhr_pkg::THRESHOLD_RESET;
      cfg.run_timeout     <= swhr_pkg::TIMEOUT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        swhr_pkg::REG_START_LOW_TICKS: cfg.start_low_ticks <= cfg_data[14:0];
        swhr_pkg::REG_RELEASE_TICKS:   cfg.release_ticks   <= cfg_data[7:0];
        swhr_pkg::REG_ONE_THRESHOLD:   cfg.one_threshold   <= cfg_data[7:0];
        swhr_pkg::REG_RUN_TIMEOUT:     cfg.run_timeout     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  swhr_step #(
    .MAX_TRANSITIONS(MAX_TRANSITIONS)
  ) u_step (
    .state        (state),
    .cfg          (cfg),
    .start_request(s_tdata[0]),
    .wire_level   (s_tdata[1]),
    .state_next   (state_next),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase            <= swhr_pkg::PH_IDLE;
      state.phase_ticks      <= '0;
      state.run_length       <= '0;
      state.previous_level   <= 1'b1;
      state.transition_index <= '0;
      state.bit_count        <= '0;
      state.rx_bytes         <= '0;
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // hold the result while the far side stalls
  always_ff @(posedge clk) begin
    if (in_accept) begin
      m_tdata <= {4'd0, result.data_bytes[3], result.data_bytes[2],
                  result.data_bytes[1], result.data_bytes[0],
                  result.reading_ok, result.done_res, result.busy_res,
                  result.drive_low};
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> m_tvalid)
    else $error("accepted item left no result");

  a_busy_tracks_phase: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (m_tdata[1] == (state.phase != swhr_pkg::PH_IDLE)))
    else $error("busy flag disagrees with phase");

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    (state.bit_count <= swhr_pkg::DATA_BITS) &&
    (state.transition_index <= 7'(MAX_TRANSITIONS)))
    else $error("bit or transition count out of range");

  a_ok_with_done: assert property (@(posedge clk) disable iff (rst)
    in_accept && result.reading_ok |-> result.done_res && state.phase == swhr_pkg::PH_LISTEN)
    else $error("ok raised outside the ending tick");

endmodule

[rtl/core/swhr_step.sv]
`timescale 1ns / 1ps

module swhr_step #(
  parameter int MAX_TRANSITIONS = 85
) (
  input  swhr_pkg::state_t  state,
  input  swhr_pkg::cfg_t    cfg,
  input  logic              start_request,
  input  logic              wire_level,
  output swhr_pkg::state_t  state_next,
  output swhr_pkg::result_t result
);

  localparam logic [6:0] MaxTrn = 7'(MAX_TRANSITIONS);

  swhr_pkg::state_t s;
  logic [14:0] tick_inc;
  logic [8:0]  run_inc;
  logic [7:0]  sum;
  logic [2:0]  byte_sel;
  logic        done;

  always_comb begin
    s        = state;
    result   = '0;
    done     = 1'b0;
    tick_inc = '0;
    run_inc  = '0;
    sum      = '0;
    byte_sel = '0;

    // a start is taken only when idle; the same tick is the first low tick
    if (state.phase == swhr_pkg::PH_IDLE && start_request) begin
      s.phase            = swhr_pkg::PH_DRIVE;
      s.phase_ticks      = '0;
      s.run_length       = '0;
      s.transition_index = '0;
      s.bit_count        = '0;
      s.rx_bytes         = '0;
    end

    tick_inc = s.phase_ticks + 15'd1;

    case (s.phase)
      swhr_pkg::PH_DRIVE: begin
        result.drive_low = 1'b1;
        s.phase_ticks    = tick_inc;
        if (tick_inc >= cfg.start_low_ticks) begin
          s.phase       = swhr_pkg::PH_RELEASE;
          s.phase_ticks = '0;
        end
      end
      swhr_pkg::PH_RELEASE: begin
        s.phase_ticks = tick_inc;
        if (tick_inc >= {7'd0, cfg.release_ticks}) begin
          s.phase          = swhr_pkg::PH_LISTEN;
          s.phase_ticks    = '0;
          s.previous_level = 1'b1;
          s.run_length     = '0;
        end
      end
      swhr_pkg::PH_LISTEN: begin
        if (wire_level == s.previous_level) begin
          run_inc = {1'b0, s.run_length} + 9'd1;
          if (run_inc >= {1'b0, cfg.run_timeout}) begin
            done = 1'b1;
          end else begin
            s.run_length = run_inc[7:0];
          end
        end else begin
          s.previous_level = wire_level;
          // even-indexed transitions from the fifth on close data bits
          if (s.transition_index >= swhr_pkg::FIRST_BIT_TRN && !s.transition_index[0] &&
              s.bit_count < swhr_pkg::DATA_BITS) begin
            byte_sel             = s.bit_count[5:3];
            s.rx_bytes[byte_sel] = {s.rx_bytes[byte_sel][6:0],
                                    (s.run_length > cfg.one_threshold)};
            s.bit_count          = s.bit_count + 6'd1;
          end
          s.transition_index = s.transition_index + 7'd1;
          s.run_length       = '0;
          if (s.transition_index >= MaxTrn) begin
            done = 1'b1;
          end
        end
        if (done) begin
          sum = s.rx_bytes[0] + s.rx_bytes[1] + s.rx_bytes[2] + s.rx_bytes[3];
          result.reading_ok = (s.bit_count >= swhr_pkg::DATA_BITS) &&
                              (s.rx_bytes[4] == sum);
          result.data_bytes = s.rx_bytes[3:0];
          s.phase           = swhr_pkg::PH_IDLE;
          s.phase_ticks     = '0;
        end
      end
      default: ;
    endcase

    result.done_res = done;
    result.busy_res = (s.phase != swhr_pkg::PH_IDLE);
    state_next      = s;
  end

endmodule
